@@ design/tms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tms_pkg: shared types and constants for the tactile matrix scan sequencer
// Channel payloads, opcodes, register indexes and register reset values.
// ---------------------------------------------------------------------------
package tms_pkg;

	// opcodes of an input request
	typedef enum logic [2:0] {
		OP_START  = 3'd0,
		OP_TICK   = 3'd1,
		OP_STOP   = 3'd2,
		OP_RESUME = 3'd3,
		OP_READ   = 3'd4
	} opcode_t;

	// configuration register indexes
	typedef enum logic [7:0] {
		REG_SELECT_COUNT   = 8'd0,
		REG_SELECT_CELLS   = 8'd1,
		REG_ROW_PIN_OFFSET = 8'd2,
		REG_COL_PIN_OFFSET = 8'd3
	} reg_index_t;

	localparam logic [3:0]  LIST_MAX          = 4'd8;
	localparam logic [3:0]  SELECT_COUNT_RST  = 4'd8;
	localparam logic [63:0] SELECT_CELLS_RST  = 64'h7161514130201000;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [11:0] adc_sample;
		logic [3:0]  read_row;
		logic [3:0]  read_col;
	} item_t;

	typedef struct packed {
		logic [3:0]  mux_row_code;
		logic [3:0]  mux_col_code;
		logic        frame_done;
		logic        scan_active;
		logic [11:0] read_value;
	} result_t;

	typedef struct packed {
		logic [7:0]  reg_index;
		logic [63:0] wdata;
	} cfg_t;

	// frame store port controls
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

endpackage
`default_nettype wire

@@ design/tms_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tms_stream_if: valid/ready channel
// Carries one payload of a chosen type per accepted request.
// ---------------------------------------------------------------------------
interface tms_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/tms_frame_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tms_frame_store: sample memory with per-cell valid bits
// One write and one registered read per cycle; unwritten cells read as zero.
// ---------------------------------------------------------------------------
module tms_frame_store #(
	parameter int CELLS  = 64,
	parameter int DATA_W = 12,
	parameter int ADDR_W = 6
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tms_pkg::store_ctl_t ctl,
	input  wire logic [ADDR_W-1:0]   wr_addr,
	input  wire logic [DATA_W-1:0]   wr_data,
	input  wire logic [ADDR_W-1:0]   rd_addr,
	output logic      [DATA_W-1:0]   rd_data
);

	logic [DATA_W-1:0] mem [CELLS];
	logic [CELLS-1:0]  valid_q;
	logic [DATA_W-1:0] rdata_q;
	logic              rvalid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rvalid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule
`default_nettype wire

@@ design/tactile_matrix_scan_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tactile_matrix_scan_sequencer: multiplexed tactile sensor matrix scanner
// Walks a select list or the full raster, stores one sample per cell and
// answers cell reads; reports mux codes and scan flags per request.
// ---------------------------------------------------------------------------
//
//  channel  | dir | payload                                        | role
//  ---------+-----+------------------------------------------------+------------------
//  items    | in  | opcode, adc_sample, read_row, read_col         | scan commands
//  results  | out | mux_row_code, mux_col_code, frame_done,        | status per request
//           |     | scan_active, read_value                        |
//  cfg      | in  | reg_index, wdata                               | register writes
//
//  State update and store write happen at the accept edge, and the result
//  lands in the output register at that same edge.
//  A new request is taken every cycle while the output register is empty or
//  being drained; a stalled result blocks only the next request.
//  Reads use the one registered read port of the frame store.
//  Reset clears scan state and the store valid bits; no clearing pass.
//  cfg is always ready.
// ---------------------------------------------------------------------------
module tactile_matrix_scan_sequencer #(
	parameter int ARRAY_ROWS  = 8,
	parameter int ARRAY_COLS  = 8,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tms_stream_if.sink   items,
	tms_stream_if.source results,
	tms_stream_if.sink   cfg
);

	localparam int CELLS  = ARRAY_ROWS * ARRAY_COLS;
	localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

	// last row / column as 4-bit codes for the raster walk
	localparam logic [3:0] LAST_ROW = 4'(ARRAY_ROWS - 1);
	localparam logic [3:0] LAST_COL = 4'(ARRAY_COLS - 1);
	localparam logic [4:0] ROWS_5   = 5'(ARRAY_ROWS);
	localparam logic [4:0] COLS_5   = 5'(ARRAY_COLS);
	localparam logic [8:0] COLS_9   = 9'(ARRAY_COLS);

	// configuration registers
	logic [3:0]  select_count_q;
	logic [63:0] select_cells_q;
	logic [3:0]  row_pin_offset_q;
	logic [3:0]  col_pin_offset_q;

	// scan state
	logic [3:0] cur_row_q;
	logic [3:0] cur_col_q;
	logic [2:0] list_pos_q;
	logic       done_q;
	logic       running_q;

	// output register
	logic                  out_valid_q;
	logic [3:0]            mux_row_q;
	logic [3:0]            mux_col_q;
	logic                  frame_done_q;
	logic                  scan_active_q;
	logic                  rd_hit_q;

	logic                  accept;
	tms_pkg::item_t        item;
	logic [3:0]            eff_count;
	logic                  list_mode;
	logic [3:0]            pos_inc;
	logic [2:0]            adv_pos;
	logic [7:0]            adv_entry;
	logic [3:0]            nxt_row;
	logic [3:0]            nxt_col;
	logic [2:0]            nxt_pos;
	logic                  nxt_done;
	logic                  nxt_running;
	logic                  cur_in_array;
	logic                  rd_in_array;
	tms_pkg::store_ctl_t   store_ctl;
	logic [8:0]            wr_addr_w;
	logic [8:0]            rd_addr_w;
	logic [SAMPLE_BITS-1:0] store_rd_data;

	assign item   = items.data;
	assign accept = items.valid && items.ready;

	// skid-free output register: next request enters when the slot frees up
	assign items.ready = !out_valid_q || results.ready;
	assign cfg.ready   = 1'b1;

	// -----------------------------------------------------------------------
	// configuration writes
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_count_q   <= tms_pkg::SELECT_COUNT_RST;
			select_cells_q   <= tms_pkg::SELECT_CELLS_RST;
			row_pin_offset_q <= '0;
			col_pin_offset_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.data.reg_index)
				tms_pkg::REG_SELECT_COUNT:   select_count_q   <= cfg.data.wdata[3:0];
				tms_pkg::REG_SELECT_CELLS:   select_cells_q   <= cfg.data.wdata;
				tms_pkg::REG_ROW_PIN_OFFSET: row_pin_offset_q <= cfg.data.wdata[3:0];
				tms_pkg::REG_COL_PIN_OFFSET: col_pin_offset_q <= cfg.data.wdata[3:0];
				default: ;
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// scan position logic
	// -----------------------------------------------------------------------
	// counts above eight clamp to the list length
	assign eff_count = (select_count_q > tms_pkg::LIST_MAX) ? tms_pkg::LIST_MAX
		: select_count_q;
	assign list_mode = (eff_count != 4'd0);

	// list advance: a position at or past the count wraps and ends the frame
	assign pos_inc   = {1'b0, list_pos_q} + 4'd1;
	assign adv_pos   = (pos_inc >= eff_count) ? 3'd0 : pos_inc[2:0];
	assign adv_entry = select_cells_q[{adv_pos, 3'b000} +: 8];

	assign cur_in_array = ({1'b0, cur_row_q} < ROWS_5) && ({1'b0, cur_col_q} < COLS_5);
	assign rd_in_array  = ({1'b0, item.read_row} < ROWS_5)
		&& ({1'b0, item.read_col} < COLS_5);

	always_comb begin
		nxt_row     = cur_row_q;
		nxt_col     = cur_col_q;
		nxt_pos     = list_pos_q;
		nxt_done    = done_q;
		nxt_running = running_q;
		store_ctl   = '0;
		case (item.opcode)
			tms_pkg::OP_START: begin
				if (list_mode) begin
					nxt_pos = 3'd0;
					nxt_row = select_cells_q[7:4];
					nxt_col = select_cells_q[3:0];
				end else begin
					nxt_row = 4'd0;
					nxt_col = 4'd0;
				end
				nxt_done    = 1'b0;
				nxt_running = 1'b1;
			end
			tms_pkg::OP_TICK: begin
				if (running_q) begin
					store_ctl.wr_en = accept && cur_in_array;
					if (list_mode) begin
						nxt_pos = adv_pos;
						nxt_row = adv_entry[7:4];
						nxt_col = adv_entry[3:0];
						if (pos_inc >= eff_count) begin
							nxt_done    = 1'b1;
							nxt_running = 1'b0;
						end
					end else if (cur_col_q >= LAST_COL) begin
						// end of row; out-of-array columns also wrap here
						nxt_col = 4'd0;
						if (cur_row_q >= LAST_ROW) begin
							nxt_row     = 4'd0;
							nxt_done    = 1'b1;
							nxt_running = 1'b0;
						end else begin
							nxt_row = cur_row_q + 4'd1;
						end
					end else begin
						nxt_col = cur_col_q + 4'd1;
					end
				end
			end
			tms_pkg::OP_STOP: begin
				nxt_running = 1'b0;
			end
			tms_pkg::OP_RESUME: begin
				nxt_done    = 1'b0;
				nxt_running = 1'b1;
			end
			tms_pkg::OP_READ: begin
				store_ctl.rd_en = accept && rd_in_array;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q  <= '0;
			cur_col_q  <= '0;
			list_pos_q <= '0;
			done_q     <= 1'b0;
			running_q  <= 1'b0;
		end else if (accept) begin
			cur_row_q  <= nxt_row;
			cur_col_q  <= nxt_col;
			list_pos_q <= nxt_pos;
			done_q     <= nxt_done;
			running_q  <= nxt_running;
		end
	end

	// -----------------------------------------------------------------------
	// frame store
	// -----------------------------------------------------------------------
	assign wr_addr_w = 9'(cur_row_q) * COLS_9 + 9'(cur_col_q);
	assign rd_addr_w = 9'(item.read_row) * COLS_9 + 9'(item.read_col);

	tms_frame_store #(
		.CELLS  (CELLS),
		.DATA_W (SAMPLE_BITS),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (store_ctl),
		.wr_addr (wr_addr_w[ADDR_W-1:0]),
		.wr_data (SAMPLE_BITS'(item.adc_sample)),
		.rd_addr (rd_addr_w[ADDR_W-1:0]),
		.rd_data (store_rd_data)
	);

	// -----------------------------------------------------------------------
	// result register: status after the request
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rd_hit_q    <= 1'b0;
		end else if (items.ready) begin
			out_valid_q <= items.valid;
			if (accept) begin
				rd_hit_q <= store_ctl.rd_en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mux_row_q     <= nxt_row + row_pin_offset_q;
			mux_col_q     <= nxt_col + col_pin_offset_q;
			frame_done_q  <= nxt_done;
			scan_active_q <= nxt_running;
		end
	end

	assign results.valid             = out_valid_q;
	assign results.data.mux_row_code = mux_row_q;
	assign results.data.mux_col_code = mux_col_q;
	assign results.data.frame_done   = frame_done_q;
	assign results.data.scan_active  = scan_active_q;
	assign results.data.read_value   = rd_hit_q ? 12'(store_rd_data) : 12'd0;

	// -----------------------------------------------------------------------
	// assertions
	// -----------------------------------------------------------------------
	// frame end always stops the scan; start/resume clear done
	a_done_not_running: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_q && running_q))
		else $error("frame done while scan running");

	// the store is written only by ticks of a running scan
	a_write_when_running: assert property (@(posedge clk) disable iff (!arst_n)
		store_ctl.wr_en |-> (running_q && item.opcode == tms_pkg::OP_TICK))
		else $error("store write outside a running tick");

	// a tick while stopped leaves the position alone
	a_idle_tick_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.opcode == tms_pkg::OP_TICK && !running_q)
		|=> ($stable(cur_row_q) && $stable(cur_col_q) && $stable(list_pos_q)))
		else $error("stopped tick moved the scan position");

	// only read requests return data
	a_read_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.opcode != tms_pkg::OP_READ) |=> (results.data.read_value == 12'd0))
		else $error("nonzero read value on a non-read request");

endmodule
`default_nettype wire

@@ dv/tactile_matrix_scan_sequencer_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tactile_matrix_scan_sequencer_tb: self-checking bench for the scan sequencer
// Feeds scan commands through a queued driver, predicts every status result
// with a local scan model, and checks each returned result field by field
// while both handshake sides stall at random.
// ---------------------------------------------------------------------------
module tactile_matrix_scan_sequencer_tb;

	localparam int ROWS        = 8;
	localparam int COLS        = 8;
	localparam int SAMPLE_BITS = 12;
	localparam int CELLS       = ROWS * COLS;
	// no handshake at all for this many cycles means the block hung
	localparam int HANG_LIMIT  = 4000;
	// opcodes the block has to ignore
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	tms_stream_if #(.payload_t(tms_pkg::item_t))   cmd_if ();
	tms_stream_if #(.payload_t(tms_pkg::result_t)) status_if ();
	tms_stream_if #(.payload_t(tms_pkg::cfg_t))    cfg_if ();

	tactile_matrix_scan_sequencer #(
		.ARRAY_ROWS (ROWS),
		.ARRAY_COLS (COLS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (cmd_if),
		.results(status_if),
		.cfg    (cfg_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---- scan model: registers and state as the block should hold them ----
	logic [3:0]  sel_count;
	logic [63:0] sel_cells;
	logic [3:0]  row_ofs;
	logic [3:0]  col_ofs;
	logic [3:0]  scan_row;
	logic [3:0]  scan_col;
	logic [2:0]  list_idx;
	logic        frame_done;
	logic        scanning;
	logic [SAMPLE_BITS-1:0] frame_mem [CELLS];

	tms_pkg::item_t   cmd_queue[$];   // commands waiting for the driver
	tms_pkg::result_t status_due[$];  // predicted status, oldest first
	int      items_taken;
	int      bad_fields;
	int      hang_cycles;

	function automatic int list_len();
		return (sel_count > tms_pkg::LIST_MAX) ? int'(tms_pkg::LIST_MAX) : int'(sel_count);
	endfunction

	function automatic bit in_array(logic [3:0] r, logic [3:0] c);
		return (r < ROWS) && (c < COLS);
	endfunction

	function automatic void load_entry();
		logic [7:0] entry;
		entry    = sel_cells[list_idx*8 +: 8];
		scan_row = entry[7:4];
		scan_col = entry[3:0];
	endfunction

	function automatic void close_frame();
		frame_done = 1'b1;
		scanning   = 1'b0;
	endfunction

	// move to the next cell of the list, or the next raster cell
	function automatic void step_cell();
		int nxt;
		if (list_len() > 0) begin
			nxt = int'(list_idx) + 1;
			if (nxt >= list_len()) begin
				nxt = 0;
				close_frame();
			end
			list_idx = nxt[2:0];
			load_entry();
		end else if (scan_col >= COLS - 1) begin
			// also catches a column left out of the array by list mode
			scan_col = '0;
			if (scan_row >= ROWS - 1) begin
				scan_row = '0;
				close_frame();
			end else begin
				scan_row = scan_row + 4'd1;
			end
		end else begin
			scan_col = scan_col + 4'd1;
		end
	endfunction

	// apply one command to the model, return the status the block must report
	function automatic tms_pkg::result_t next_status(tms_pkg::item_t cmd);
		tms_pkg::result_t st;
		st.read_value = '0;
		case (cmd.opcode)
			tms_pkg::OP_START: begin
				if (list_len() > 0) begin
					list_idx = '0;
					load_entry();
				end else begin
					scan_row = '0;
					scan_col = '0;
				end
				frame_done = 1'b0;
				scanning   = 1'b1;
			end
			tms_pkg::OP_TICK: begin
				// ticks while stopped are dropped
				if (scanning) begin
					if (in_array(scan_row, scan_col))
						frame_mem[scan_row*COLS + scan_col] = cmd.adc_sample[SAMPLE_BITS-1:0];
					step_cell();
				end
			end
			tms_pkg::OP_STOP: scanning = 1'b0;
			tms_pkg::OP_RESUME: begin
				frame_done = 1'b0;
				scanning   = 1'b1;
			end
			tms_pkg::OP_READ: begin
				if (in_array(cmd.read_row, cmd.read_col))
					st.read_value = 12'(frame_mem[cmd.read_row*COLS + cmd.read_col]);
			end
			default: ;
		endcase
		st.mux_row_code = scan_row + row_ofs;
		st.mux_col_code = scan_col + col_ofs;
		st.frame_done   = frame_done;
		st.scan_active  = scanning;
		return st;
	endfunction

	// ---- random stalls, with one calm window of back-to-back traffic ----
	function automatic bit stall_now();
		if (items_taken >= 400 && items_taken < 560)
			return 1'b0;
		return $urandom_range(99) < 13;
	endfunction

	// ---- command driver ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_if.valid <= 1'b0;
			cmd_if.data  <= '0;
		end else begin
			if (cmd_if.valid && cmd_if.ready) begin
				status_due.push_back(next_status(cmd_if.data));
				items_taken++;
			end
			if (cmd_if.valid && !cmd_if.ready) begin
				// request still waiting: hold it
			end else if (cmd_queue.size() != 0 && !stall_now()) begin
				cmd_if.valid <= 1'b1;
				cmd_if.data  <= cmd_queue.pop_front();
			end else begin
				cmd_if.valid <= 1'b0;
			end
		end
	end

	// ---- status monitor and checker ----
	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			bad_fields++;
			if (bad_fields <= 10)
				$display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tms_pkg::result_t want;
		if (!arst_n) begin
			status_if.ready <= 1'b0;
		end else begin
			status_if.ready <= !stall_now();
			if (status_if.valid && status_if.ready) begin
				if (status_due.size() == 0) begin
					bad_fields++;
					if (bad_fields <= 10)
						$display("%0t unexpected status %h", $time, status_if.data);
				end else begin
					want = status_due.pop_front();
					check_field("mux_row_code", want.mux_row_code, status_if.data.mux_row_code);
					check_field("mux_col_code", want.mux_col_code, status_if.data.mux_col_code);
					check_field("frame_done", want.frame_done, status_if.data.frame_done);
					check_field("scan_active", want.scan_active, status_if.data.scan_active);
					check_field("read_value", want.read_value, status_if.data.read_value);
				end
			end
		end
	end

	// ---- watchdog: any handshake resets the count ----
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_if.valid && cmd_if.ready) || (status_if.valid && status_if.ready) ||
			    (cfg_if.valid && cfg_if.ready)) begin
				hang_cycles = 0;
			end else if (++hang_cycles >= HANG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ---- stimulus helpers ----
	function automatic tms_pkg::item_t make_cmd(logic [2:0] op);
		tms_pkg::item_t cmd;
		cmd.opcode     = op;
		cmd.adc_sample = 12'($urandom_range(4095));
		cmd.read_row   = 4'($urandom_range(15));
		cmd.read_col   = 4'($urandom_range(15));
		return cmd;
	endfunction

	// mostly reads inside the array, some anywhere in the 4-bit range
	function automatic tms_pkg::item_t make_read();
		tms_pkg::item_t cmd;
		cmd = make_cmd(tms_pkg::OP_READ);
		if ($urandom_range(9) < 7) begin
			cmd.read_row = 4'($urandom_range(ROWS - 1));
			cmd.read_col = 4'($urandom_range(COLS - 1));
		end
		return cmd;
	endfunction

	// a well-formed frame: start (or resume), then enough ticks to finish,
	// with reads and the odd stop / dropped tick / resume mixed in
	function automatic void queue_frame();
		int len;
		int r;
		len = (list_len() > 0) ? list_len() : CELLS;
		cmd_queue.push_back(make_cmd(($urandom_range(4) == 0) ? tms_pkg::OP_RESUME
			: tms_pkg::OP_START));
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (r < 15) begin
				cmd_queue.push_back(make_read());
			end else if (r < 19) begin
				cmd_queue.push_back(make_cmd(tms_pkg::OP_STOP));
				cmd_queue.push_back(make_cmd(tms_pkg::OP_TICK));
				cmd_queue.push_back(make_cmd(tms_pkg::OP_RESUME));
			end
			cmd_queue.push_back(make_cmd(tms_pkg::OP_TICK));
		end
	endfunction

	task automatic wait_idle();
		do @(posedge clk);
		while (cmd_queue.size() != 0 || cmd_if.valid || status_due.size() != 0);
		// the block buffers a single result, so the spare cycles below are plenty
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(tms_pkg::reg_index_t idx, logic [63:0] val);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= '{reg_index: idx, wdata: val};
		do @(posedge clk);
		while (!cfg_if.ready);
		case (idx)
			tms_pkg::REG_SELECT_COUNT:   sel_count = val[3:0];
			tms_pkg::REG_SELECT_CELLS:   sel_cells = val;
			tms_pkg::REG_ROW_PIN_OFFSET: row_ofs   = val[3:0];
			tms_pkg::REG_COL_PIN_OFFSET: col_ofs   = val[3:0];
			default: ;
		endcase
		cfg_if.valid <= 1'b0;
	endtask

	// list of eight cells all inside the array
	function automatic logic [63:0] cells_in_array();
		logic [63:0] v;
		for (int k = 0; k < 8; k++)
			v[k*8 +: 8] = {4'($urandom_range(ROWS - 1)), 4'($urandom_range(COLS - 1))};
		return v;
	endfunction

	// scan state is not reset between phases, so a new count can find the
	// list index past its end, or raster mode can start off the array
	task automatic run_phase(logic [3:0] cnt, logic [63:0] cells, logic [3:0] ro,
	                         logic [3:0] co, int n_cmds);
		int target;
		wait_idle();
		write_reg(tms_pkg::REG_SELECT_COUNT, 64'(cnt));
		write_reg(tms_pkg::REG_SELECT_CELLS, cells);
		write_reg(tms_pkg::REG_ROW_PIN_OFFSET, 64'(ro));
		write_reg(tms_pkg::REG_COL_PIN_OFFSET, 64'(co));
		target = items_taken + cmd_queue.size() + n_cmds;
		while (items_taken + cmd_queue.size() < target) begin
			if ($urandom_range(99) < 85) begin
				queue_frame();
			end else begin
				// noise: any opcode, any field values
				repeat ($urandom_range(6, 1))
					cmd_queue.push_back(make_cmd(3'($urandom_range(7))));
			end
			// keep the queue short so the watchdog sees steady progress
			while (cmd_queue.size() > 64)
				@(posedge clk);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cmd_if.valid    = 1'b0;
		cmd_if.data     = '0;
		cfg_if.valid    = 1'b0;
		cfg_if.data     = '0;
		status_if.ready = 1'b0;
		items_taken     = 0;
		bad_fields      = 0;
		hang_cycles     = 0;
		sel_count       = tms_pkg::SELECT_COUNT_RST;
		sel_cells       = tms_pkg::SELECT_CELLS_RST;
		row_ofs         = '0;
		col_ofs         = '0;
		scan_row        = '0;
		scan_col        = '0;
		list_idx        = '0;
		frame_done      = 1'b0;
		scanning        = 1'b0;
		foreach (frame_mem[i])
			frame_mem[i] = '0;

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed part, reset configuration (default eight-cell list)
		cmd_queue.push_back(make_read());                    // store cleared at reset
		cmd_queue.push_back(make_cmd(tms_pkg::OP_TICK));     // tick while stopped
		cmd_queue.push_back(make_cmd(tms_pkg::OP_START));
		for (int i = 0; i < 8; i++) begin
			tms_pkg::item_t t;
			t = make_cmd(tms_pkg::OP_TICK);
			if (i == 0) t.adc_sample = 12'hFFF;
			if (i == 1) t.adc_sample = 12'h000;
			cmd_queue.push_back(t);                          // last tick closes the frame
		end
		begin
			tms_pkg::item_t rd;
			rd = make_cmd(tms_pkg::OP_READ);
			rd.read_row = 4'd0;  rd.read_col = 4'd0;  cmd_queue.push_back(rd);
			rd.read_row = 4'd7;  rd.read_col = 4'd1;  cmd_queue.push_back(rd);
			rd.read_row = 4'd15; rd.read_col = 4'd15; cmd_queue.push_back(rd);
			rd.read_row = 4'd0;  rd.read_col = 4'd8;  cmd_queue.push_back(rd);
			rd.read_row = 4'd8;  rd.read_col = 4'd0;  cmd_queue.push_back(rd);
		end
		cmd_queue.push_back(make_cmd(tms_pkg::OP_STOP));
		cmd_queue.push_back(make_cmd(tms_pkg::OP_RESUME));   // resume keeps position
		cmd_queue.push_back(make_cmd(tms_pkg::OP_TICK));
		cmd_queue.push_back(make_cmd(tms_pkg::OP_STOP));
		cmd_queue.push_back(make_cmd(tms_pkg::OP_TICK));
		for (int k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++)
			cmd_queue.push_back(make_cmd(3'(k)));

		// random part across register settings, extremes included
		run_phase(4'd8,  cells_in_array(),       4'd15, 4'd15, 110);
		run_phase(4'd0,  64'(0),                 4'd0,  4'd0,  130);
		run_phase(4'd15, {$urandom, $urandom},   4'd15, 4'd0,  110);
		run_phase(4'd1,  {$urandom, $urandom},   4'd0,  4'd15, 90);
		run_phase(4'd3,  {$urandom, $urandom},   4'($urandom_range(15)),
		          4'($urandom_range(15)), 100);
		run_phase(4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 4'd15, 130);
		run_phase(4'd8,  64'h0,                  4'd0,  4'd0,  90);
		run_phase(4'($urandom_range(15)), {$urandom, $urandom},
		          4'($urandom_range(15)), 4'($urandom_range(15)), 110);
		run_phase(4'd8,  tms_pkg::SELECT_CELLS_RST, 4'd0, 4'd0, 100);

		wait_idle();
		repeat (10) @(posedge clk);
		if (bad_fields == 0 && status_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ tactile_matrix_scan_sequencer.f @@
design/tms_pkg.sv
design/tms_stream_if.sv
design/tms_frame_store.sv
design/tactile_matrix_scan_sequencer.sv
dv/tactile_matrix_scan_sequencer_tb.sv
